@@ rtl/core/spct_pkg.sv @@
package spct_pkg;

   typedef enum logic [1:0] {
      OP_RECT_RECT = 2'd0,
      OP_CIRC_CIRC = 2'd1,
      OP_CIRC_RECT = 2'd2
   } opcode_type;

   // corners of the rectangle checked against the circle
   localparam int unsigned CORNERS = 4;

   // doubled coordinate differences need this many bits beyond COORD_BITS
   localparam int unsigned MAG_GUARD = 2;

endpackage

@@ rtl/core/shape_pair_collision_test.sv @@
// Shape pair collision test: 2D narrow-phase check of two shapes.
//
// Request channel: pulse start with req_opcode and both shapes (signed Q12.4
// centers, unsigned Q11.4 sizes; a circle uses its size_x as radius). A request
// is taken on every edge where start is high and busy is low; busy is always
// low, so one request per cycle is sustained indefinitely.
// Response channel: rsp_valid is high for exactly one cycle with rsp_hit.
// There is no backpressure; the consumer must take every response.
// Stages: edge/box build, compares and corner deltas, squares,
// sums of squares, final compare. Throughput: one request per clock.
// Responses come back in request order, one per request.
// Opcode 3 returns rsp_hit = 0.
// Reset (synchronous, active high) flushes all in-flight requests; no
// response is produced for them. There is no other state to clear.
module shape_pair_collision_test
   import spct_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_opcode,
   input  logic signed [COORD_BITS-1:0] req_a_x,
   input  logic signed [COORD_BITS-1:0] req_a_y,
   input  logic [COORD_BITS-2:0]        req_a_size_x,
   input  logic [COORD_BITS-2:0]        req_a_size_y,
   input  logic signed [COORD_BITS-1:0] req_b_x,
   input  logic signed [COORD_BITS-1:0] req_b_y,
   input  logic [COORD_BITS-2:0]        req_b_size_x,
   input  logic [COORD_BITS-2:0]        req_b_size_y,
   output logic                         rsp_valid,
   output logic                         rsp_hit
);

   // all coordinates run doubled so rectangle half sizes stay exact
   localparam int EDGE_BITS = COORD_BITS + 2;          // doubled edges
   localparam int DIFF_BITS = EDGE_BITS + 1;           // edge differences
   localparam int MAG_BITS  = COORD_BITS + MAG_GUARD;  // |difference|
   localparam int RAD_BITS  = COORD_BITS + 1;          // doubled radius
   localparam int SQ_BITS   = 2 * MAG_BITS;

   typedef logic signed [EDGE_BITS-1:0] edge_type;

   // stage B control that rides alongside the distance pipeline
   typedef struct packed {
      logic               pass;     // hit without any distance test
      logic               use_dist; // hit if any enabled corner is in range
      logic [CORNERS-1:0] mask;     // corners taking part
   } flags_type;

   assign busy = 1'b0;

   // ---------------- stage A: doubled centers and box edges ----------------
   logic       accept;
   logic       a_valid_ff, a_valid_in;
   opcode_type a_op_ff, a_op_in;
   edge_type   a_ax_ff, a_ay_ff, a_bx_ff, a_by_ff;
   edge_type   a_ax_in, a_ay_in, a_bx_in, a_by_in;
   edge_type   a_alo_x_ff, a_ahi_x_ff, a_alo_y_ff, a_ahi_y_ff;
   edge_type   a_alo_x_in, a_ahi_x_in, a_alo_y_in, a_ahi_y_in;
   edge_type   a_bx0_ff, a_bx1_ff, a_by0_ff, a_by1_ff;
   edge_type   a_bx0_in, a_bx1_in, a_by0_in, a_by1_in;
   logic [RAD_BITS-1:0] a_rad_ff, a_rad_in;
   edge_type   half_ax, half_ay, bsx, bsy, circ_r2;
   logic [COORD_BITS-1:0] rad_sum;

   assign accept     = start && !busy;
   assign a_valid_in = accept;
   assign a_op_in    = opcode_type'(req_opcode);

   assign a_ax_in = {req_a_x[COORD_BITS-1], req_a_x, 1'b0};
   assign a_ay_in = {req_a_y[COORD_BITS-1], req_a_y, 1'b0};
   assign a_bx_in = {req_b_x[COORD_BITS-1], req_b_x, 1'b0};
   assign a_by_in = {req_b_y[COORD_BITS-1], req_b_y, 1'b0};

   assign bsx     = {3'b000, req_b_size_x};
   assign bsy     = {3'b000, req_b_size_y};
   assign circ_r2 = {2'b00, req_a_size_x, 1'b0};

   // shape a extent: box of side 2r for a circle, else half of full size
   // (full size in doubled units)
   always_comb begin
      if (a_op_in == OP_CIRC_RECT) begin
         half_ax = circ_r2;
         half_ay = circ_r2;
      end else begin
         half_ax = {3'b000, req_a_size_x};
         half_ay = {3'b000, req_a_size_y};
      end
   end

   assign a_alo_x_in = a_ax_in - half_ax;
   assign a_ahi_x_in = a_ax_in + half_ax;
   assign a_alo_y_in = a_ay_in - half_ay;
   assign a_ahi_y_in = a_ay_in + half_ay;
   assign a_bx0_in   = a_bx_in - bsx;
   assign a_bx1_in   = a_bx_in + bsx;
   assign a_by0_in   = a_by_in - bsy;
   assign a_by1_in   = a_by_in + bsy;

   // circle-circle compares against 2*(ra+rb), circle-rect against 2*r
   assign rad_sum  = {1'b0, req_a_size_x} + {1'b0, req_b_size_x};
   assign a_rad_in = (a_op_in == OP_CIRC_CIRC) ? {rad_sum, 1'b0}
                                               : {1'b0, req_a_size_x, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_op_ff    <= a_op_in;
      a_ax_ff    <= a_ax_in;
      a_ay_ff    <= a_ay_in;
      a_bx_ff    <= a_bx_in;
      a_by_ff    <= a_by_in;
      a_alo_x_ff <= a_alo_x_in;
      a_ahi_x_ff <= a_ahi_x_in;
      a_alo_y_ff <= a_alo_y_in;
      a_ahi_y_ff <= a_ahi_y_in;
      a_bx0_ff   <= a_bx0_in;
      a_bx1_ff   <= a_bx1_in;
      a_by0_ff   <= a_by0_in;
      a_by1_ff   <= a_by1_in;
      a_rad_ff   <= a_rad_in;
   end

   // ---------------- stage B: overlap compares, corner deltas ----------------
   function automatic logic [MAG_BITS-1:0] abs_diff(edge_type p, edge_type q);
      logic signed [DIFF_BITS-1:0] d;
      logic [DIFF_BITS-1:0]        m;
      d = {p[EDGE_BITS-1], p} - {q[EDGE_BITS-1], q};
      m = d[DIFF_BITS-1] ? (~d + 1'b1) : d;
      return m[MAG_BITS-1:0];
   endfunction

   logic      overlap, in_span;
   edge_type  ref_x [CORNERS];
   edge_type  ref_y [CORNERS];
   flags_type b_flags_ff, b_flags_in;
   logic      b_valid_ff;
   logic [MAG_BITS-1:0] b_dx_ff [CORNERS];
   logic [MAG_BITS-1:0] b_dy_ff [CORNERS];
   logic [MAG_BITS-1:0] b_dx_in [CORNERS];
   logic [MAG_BITS-1:0] b_dy_in [CORNERS];
   logic [RAD_BITS-1:0] b_rad_ff;

   // closed spans: touching edges overlap
   assign overlap = !(a_ahi_x_ff < a_bx0_ff || a_alo_x_ff > a_bx1_ff) &&
                    !(a_ahi_y_ff < a_by0_ff || a_alo_y_ff > a_by1_ff);
   // circle center strictly within the rectangle's x span or y span
   assign in_span = (a_ax_ff < a_bx1_ff && a_ax_ff > a_bx0_ff) ||
                    (a_ay_ff < a_by1_ff && a_ay_ff > a_by0_ff);

   // corner slot 0 carries the center delta for circle-circle
   assign ref_x[0] = (a_op_ff == OP_CIRC_CIRC) ? a_bx_ff : a_bx0_ff;
   assign ref_y[0] = (a_op_ff == OP_CIRC_CIRC) ? a_by_ff : a_by0_ff;
   assign ref_x[1] = a_bx1_ff;
   assign ref_y[1] = a_by1_ff;
   assign ref_x[2] = a_bx0_ff;
   assign ref_y[2] = a_by1_ff;
   assign ref_x[3] = a_bx1_ff;
   assign ref_y[3] = a_by0_ff;

   for (genvar c = 0; c < CORNERS; c++) begin : g_delta
      assign b_dx_in[c] = abs_diff(a_ax_ff, ref_x[c]);
      assign b_dy_in[c] = abs_diff(a_ay_ff, ref_y[c]);
   end

   always_comb begin
      b_flags_in = '0;
      unique case (a_op_ff)
         OP_RECT_RECT: begin
            b_flags_in.pass = overlap;
         end
         OP_CIRC_CIRC: begin
            b_flags_in.use_dist = 1'b1;
            b_flags_in.mask     = CORNERS'(1);
         end
         OP_CIRC_RECT: begin
            b_flags_in.pass     = overlap && in_span;
            b_flags_in.use_dist = overlap && !in_span;
            b_flags_in.mask     = '1;
         end
         default: begin
            b_flags_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_flags_ff <= b_flags_in;
      b_rad_ff   <= a_rad_ff;
      b_dx_ff    <= b_dx_in;
      b_dy_ff    <= b_dy_in;
   end

   // ---------------- stages C and D: squares and sums ----------------
   logic [SQ_BITS:0]   sum_sq [CORNERS];
   logic [SQ_BITS-1:0] c_rsq_ff, c_rsq_in, d_rsq_ff;
   flags_type          c_flags_ff, d_flags_ff;
   logic               c_valid_ff, d_valid_ff;

   for (genvar c = 0; c < CORNERS; c++) begin : g_dist
      spct_dist_sq #(
         .COORD_BITS (COORD_BITS)
      ) u_dist (
         .clock  (clock),
         .dx_mag (b_dx_ff[c]),
         .dy_mag (b_dy_ff[c]),
         .sum_sq (sum_sq[c])
      );
   end

   assign c_rsq_in = SQ_BITS'(b_rad_ff) * SQ_BITS'(b_rad_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_rsq_ff   <= c_rsq_in;
      d_rsq_ff   <= c_rsq_ff;
      c_flags_ff <= b_flags_ff;
      d_flags_ff <= c_flags_ff;
   end

   // ---------------- stage E: strict radius compare, response ----------------
   logic [CORNERS-1:0] near;
   logic               rsp_valid_ff, rsp_hit_ff, rsp_hit_in;

   for (genvar c = 0; c < CORNERS; c++) begin : g_near
      assign near[c] = {1'b0, d_rsq_ff} > sum_sq[c];
   end

   assign rsp_hit_in = d_flags_ff.pass ||
                       (d_flags_ff.use_dist && |(d_flags_ff.mask & near));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff <= rsp_hit_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   // ---------------- checks ----------------
   // every accepted request comes out as a response
   ast_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_valid)
      else $error("request did not produce a response after five cycles");

   // a pair is settled either by the compares or by distance, never both
   ast_flags_excl: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> !(b_flags_ff.pass && b_flags_ff.use_dist))
      else $error("pass and distance test both set");

   // a distance test always has at least one corner enabled
   ast_mask_set: assert property (@(posedge clock) disable iff (reset)
      (d_valid_ff && d_flags_ff.use_dist) |-> (d_flags_ff.mask != '0))
      else $error("distance test with no corner enabled");

endmodule

@@ rtl/core/spct_dist_sq.sv @@
// squared distance: dx^2 + dy^2, two register stages
module spct_dist_sq
   import spct_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                                    clock,
   input  logic [COORD_BITS+MAG_GUARD-1:0]         dx_mag,
   input  logic [COORD_BITS+MAG_GUARD-1:0]         dy_mag,
   output logic [2*(COORD_BITS+MAG_GUARD):0]       sum_sq
);

   localparam int MAG_BITS = COORD_BITS + MAG_GUARD;
   localparam int SQ_BITS  = 2 * MAG_BITS;

   logic [SQ_BITS-1:0] sq_x_ff, sq_x_in;
   logic [SQ_BITS-1:0] sq_y_ff, sq_y_in;
   logic [SQ_BITS:0]   sum_ff, sum_in;

   assign sq_x_in = SQ_BITS'(dx_mag) * SQ_BITS'(dx_mag);
   assign sq_y_in = SQ_BITS'(dy_mag) * SQ_BITS'(dy_mag);
   assign sum_in  = {1'b0, sq_x_ff} + {1'b0, sq_y_ff};

   always_ff @(posedge clock) begin
      sq_x_ff <= sq_x_in;
      sq_y_ff <= sq_y_in;
      sum_ff  <= sum_in;
   end

   assign sum_sq = sum_ff;

endmodule

@@ tb/shape_pair_collision_test_tb.sv @@
module shape_pair_collision_test_tb
   import spct_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS = 16;
   localparam int unsigned PIPE_LATENCY = 5;        // accept edge to response edge
   localparam int unsigned RANDOM_REQUESTS = 1700;
   localparam int unsigned CALM_TAIL = 300;         // last requests sent back to back
   localparam int unsigned CYCLE_LIMIT = 200000;

   // opcode 3 is not in the enum; the block must answer it with no hit
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // one request as seen on the req_ ports
   typedef struct {
      logic [1:0]                   opcode;
      logic signed [COORD_BITS-1:0] a_x;
      logic signed [COORD_BITS-1:0] a_y;
      logic [COORD_BITS-2:0]        a_size_x;
      logic [COORD_BITS-2:0]        a_size_y;
      logic signed [COORD_BITS-1:0] b_x;
      logic signed [COORD_BITS-1:0] b_y;
      logic [COORD_BITS-2:0]        b_size_x;
      logic [COORD_BITS-2:0]        b_size_y;
   } shape_pair_type;

   // Holds the hit flags owed by the block, oldest first, and checks
   // each response against the head of the queue.
   class collision_scoreboard;
      bit          hit_queue[$];
      int unsigned failures;

      // closed interval overlap on one axis, doubled units
      function bit spans_overlap(longint lo1, longint hi1, longint lo2, longint hi2);
         return !(hi1 < lo2 || lo1 > hi2);
      endfunction

      // r^2 > dx^2 + dy^2; all terms stay well under 2^40
      function bit in_reach(longint r, longint dx, longint dy);
         return r * r > dx * dx + dy * dy;
      endfunction

      function bit shapes_collide(shape_pair_type p);
         longint ax, ay, asx, asy, bx0, bx1, by0, by1, r2;
         bit     hit;
         // work in doubled coordinates so half sizes stay exact
         ax  = 2 * longint'(p.a_x);
         ay  = 2 * longint'(p.a_y);
         asx = longint'(p.a_size_x);
         asy = longint'(p.a_size_y);
         bx0 = 2 * longint'(p.b_x) - longint'(p.b_size_x);
         bx1 = 2 * longint'(p.b_x) + longint'(p.b_size_x);
         by0 = 2 * longint'(p.b_y) - longint'(p.b_size_y);
         by1 = 2 * longint'(p.b_y) + longint'(p.b_size_y);
         hit = 1'b0;
         case (p.opcode)
            OP_RECT_RECT: begin
               hit = spans_overlap(ax - asx, ax + asx, bx0, bx1) &&
                     spans_overlap(ay - asy, ay + asy, by0, by1);
            end
            OP_CIRC_CIRC: begin
               hit = in_reach(2 * (asx + longint'(p.b_size_x)),
                              ax - 2 * longint'(p.b_x), ay - 2 * longint'(p.b_y));
            end
            OP_CIRC_RECT: begin
               r2 = 2 * asx;
               if (spans_overlap(ax - r2, ax + r2, bx0, bx1) &&
                   spans_overlap(ay - r2, ay + r2, by0, by1)) begin
                  if ((ax < bx1 && ax > bx0) || (ay < by1 && ay > by0))
                     hit = 1'b1;
                  else
                     hit = in_reach(r2, ax - bx0, ay - by0) ||
                           in_reach(r2, ax - bx1, ay - by1) ||
                           in_reach(r2, ax - bx0, ay - by1) ||
                           in_reach(r2, ax - bx1, ay - by0);
               end
            end
            default: hit = 1'b0;
         endcase
         return hit;
      endfunction

      function void note_request(shape_pair_type p);
         hit_queue = {hit_queue, shapes_collide(p)};
      endfunction

      function void check_response(logic hit);
         bit expected;
         if (hit_queue.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual hit=%b", $time, hit);
            failures++;
            return;
         end
         expected = hit_queue.pop_front();
         if (hit !== expected) begin
            $display("%0t: hit mismatch, expected %b, actual %b", $time, expected, hit);
            failures++;
         end
      endfunction

      function int unsigned pending();
         return hit_queue.size();
      endfunction
   endclass

   // every input known from time zero
   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [1:0]                   req_opcode = OP_RECT_RECT;
   logic signed [COORD_BITS-1:0] req_a_x = '0;
   logic signed [COORD_BITS-1:0] req_a_y = '0;
   logic [COORD_BITS-2:0]        req_a_size_x = '0;
   logic [COORD_BITS-2:0]        req_a_size_y = '0;
   logic signed [COORD_BITS-1:0] req_b_x = '0;
   logic signed [COORD_BITS-1:0] req_b_y = '0;
   logic [COORD_BITS-2:0]        req_b_size_x = '0;
   logic [COORD_BITS-2:0]        req_b_size_y = '0;
   logic                         rsp_valid;
   logic                         rsp_hit;

   collision_scoreboard hit_board = new();
   int unsigned         cycle_count = 0;

   shape_pair_collision_test #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_a_x(req_a_x),
      .req_a_y(req_a_y),
      .req_a_size_x(req_a_size_x),
      .req_a_size_y(req_a_size_y),
      .req_b_x(req_b_x),
      .req_b_y(req_b_y),
      .req_b_size_x(req_b_size_x),
      .req_b_size_y(req_b_size_y),
      .rsp_valid(rsp_valid),
      .rsp_hit(rsp_hit)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Responses cannot be held off, so every rsp_valid cycle is taken.
   // Sampling right after the edge sees the values from before it.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         hit_board.check_response(rsp_hit);
   end

   // watchdog: also catches requests that never get a response
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Present one request and hold it until an edge with busy low takes it.
   // start stays high on return, so a following request goes out back to back.
   task automatic send_request(input shape_pair_type p);
      start        <= 1'b1;
      req_opcode   <= p.opcode;
      req_a_x      <= p.a_x;
      req_a_y      <= p.a_y;
      req_a_size_x <= p.a_size_x;
      req_a_size_y <= p.a_size_y;
      req_b_x      <= p.b_x;
      req_b_y      <= p.b_y;
      req_b_size_x <= p.b_size_x;
      req_b_size_y <= p.b_size_y;
      do @(posedge clock); while (busy !== 1'b0);
      hit_board.note_request(p);
   endtask

   task automatic pause_requests(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // hold off the sender until every owed response is back
   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (hit_board.pending() != 0) @(posedge clock);
   endtask

   task automatic send_fields(input logic [1:0] op,
                              input int ax, input int ay, input int asx, input int asy,
                              input int bx, input int by, input int bsx, input int bsy);
      shape_pair_type p;
      p.opcode   = op;
      p.a_x      = COORD_BITS'(ax);
      p.a_y      = COORD_BITS'(ay);
      p.a_size_x = (COORD_BITS-1)'(asx);
      p.a_size_y = (COORD_BITS-1)'(asy);
      p.b_x      = COORD_BITS'(bx);
      p.b_y      = COORD_BITS'(by);
      p.b_size_x = (COORD_BITS-1)'(bsx);
      p.b_size_y = (COORD_BITS-1)'(bsy);
      send_request(p);
   endtask

   // Mostly pairs placed close together so that overlap, touch, span and
   // corner cases all come up; the rest are fully random words so that every
   // bit of every field toggles. Offsets may wrap around the coordinate range.
   function automatic shape_pair_type random_pair();
      shape_pair_type p;
      int unsigned scale;
      p.opcode = ($urandom_range(0, 15) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
      if ($urandom_range(0, 4) == 0) begin
         p.a_x      = COORD_BITS'($urandom);
         p.a_y      = COORD_BITS'($urandom);
         p.a_size_x = (COORD_BITS-1)'($urandom);
         p.a_size_y = (COORD_BITS-1)'($urandom);
         p.b_x      = COORD_BITS'($urandom);
         p.b_y      = COORD_BITS'($urandom);
         p.b_size_x = (COORD_BITS-1)'($urandom);
         p.b_size_y = (COORD_BITS-1)'($urandom);
      end else begin
         scale      = $urandom_range(1, 14);
         p.a_x      = COORD_BITS'($urandom);
         p.a_y      = COORD_BITS'($urandom);
         p.a_size_x = (COORD_BITS-1)'($urandom_range(0, 1 << scale));
         p.a_size_y = (COORD_BITS-1)'($urandom_range(0, 1 << scale));
         p.b_x      = p.a_x + COORD_BITS'($urandom_range(0, 2 << scale))
                            - COORD_BITS'(1 << scale);
         p.b_y      = p.a_y + COORD_BITS'($urandom_range(0, 2 << scale))
                            - COORD_BITS'(1 << scale);
         p.b_size_x = (COORD_BITS-1)'($urandom_range(0, 1 << scale));
         p.b_size_y = (COORD_BITS-1)'($urandom_range(0, 1 << scale));
      end
      return p;
   endfunction

   initial begin
      int unsigned idle_odds;
      // synchronous reset held from the start, then released on an edge
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed requests, raw Q12.4 centers and Q11.4 sizes ----
      // boxes whose edges just touch count as a hit; one step apart they miss
      send_fields(OP_RECT_RECT, 0, 0, 32, 32, 32, 0, 32, 32);
      send_fields(OP_RECT_RECT, 0, 0, 32, 32, 33, 0, 32, 32);
      // circles that just touch miss (strict compare); a step closer they hit
      send_fields(OP_CIRC_CIRC, 0, 0, 16, 0, 32, 0, 16, 0);
      send_fields(OP_CIRC_CIRC, 0, 0, 16, 0, 31, 0, 16, 0);
      // circle center strictly inside the rectangle's x span
      send_fields(OP_CIRC_RECT, 0, 0, 8, 0, 0, 10, 40, 20);
      // outside both spans: corner inside the radius hits, just outside misses
      send_fields(OP_CIRC_RECT, 0, 0, 8, 0, 10, 10, 10, 10);
      send_fields(OP_CIRC_RECT, 0, 0, 8, 0, 12, 12, 10, 10);
      // circle's bounding box clear of the rectangle
      send_fields(OP_CIRC_RECT, 0, 0, 8, 0, 20, 20, 4, 4);
      // degenerate shapes at one point
      send_fields(OP_RECT_RECT, 0, 0, 0, 0, 0, 0, 0, 0);
      send_fields(OP_CIRC_CIRC, 0, 0, 0, 0, 0, 0, 0, 0);
      send_fields(OP_CIRC_RECT, 0, 0, 0, 0, 0, 0, 0, 0);
      // unused opcode, even for overlapping shapes
      send_fields(OP_UNUSED, 0, 0, 100, 100, 0, 0, 100, 100);
      // field extremes: opposite corners of the range, largest sizes
      send_fields(OP_RECT_RECT, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767);
      send_fields(OP_CIRC_CIRC, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767);
      send_fields(OP_CIRC_RECT, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767);
      send_fields(OP_UNUSED, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767);
      send_fields(OP_CIRC_CIRC, -32768, 32767, 0, 0, 32767, -32768, 0, 0);
      send_fields(OP_CIRC_RECT, 32767, -32768, 32767, 0, -32768, 32767, 0, 32767);
      send_fields(OP_RECT_RECT, -32768, 0, 0, 32767, 32767, 0, 32767, 0);

      // let the pipeline empty before the random part
      drain_responses();

      // ---- random requests ----
      // idling odds change every 100 requests, so some stretches run with
      // no gaps at all; the tail goes back to back
      idle_odds = 0;
      for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 100 == 0)
            idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
         if (n == RANDOM_REQUESTS / 2)
            drain_responses();
         else if (n < RANDOM_REQUESTS - CALM_TAIL && $urandom_range(1, 100) <= idle_odds)
            pause_requests($urandom_range(1, 8));
         send_request(random_pair());
      end

      // wait for every owed response, then keep clocking to catch any extras
      drain_responses();
      repeat (PIPE_LATENCY + 4) @(posedge clock);

      if (hit_board.failures == 0 && hit_board.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/spct_pkg.sv
rtl/core/spct_dist_sq.sv
rtl/core/shape_pair_collision_test.sv
tb/shape_pair_collision_test_tb.sv
